/* rtl/bsm_pkg.sv */
// Shared types, codes and constants of the bank switch mapper.
package bsm_pkg;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_RESP
   } state_type;

   // Bus operation codes.
   localparam logic [2:0] OP_CPU_READ  = 3'd0;
   localparam logic [2:0] OP_CPU_WRITE = 3'd1;
   localparam logic [2:0] OP_PPU_READ  = 3'd2;
   localparam logic [2:0] OP_PPU_WRITE = 3'd3;
   localparam logic [2:0] OP_A12_OBS   = 3'd4;
   localparam logic [2:0] OP_IRQ_ACK   = 3'd5;

   // Target memory codes.
   localparam logic [2:0] TGT_NONE    = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM = 3'd1;
   localparam logic [2:0] TGT_PRG_RAM = 3'd2;
   localparam logic [2:0] TGT_CHR_ROM = 3'd3;
   localparam logic [2:0] TGT_CHR_RAM = 3'd4;

   // Pattern memory kinds.
   localparam logic [1:0] CHR_KIND_ROM = 2'd1;
   localparam logic [1:0] CHR_KIND_RAM = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PRG_BANK_COUNT = 3'd0;
   localparam logic [2:0] CSR_CHR_BANK_COUNT = 3'd1;
   localparam logic [2:0] CSR_CHR_KIND       = 3'd2;
   localparam logic [2:0] CSR_PRG_RAM        = 3'd3;
   localparam logic [2:0] CSR_A12_FILTER     = 3'd4;

   // Mapper register decode: address bits kept and the decoded registers.
   localparam logic [15:0] REG_MASK        = 16'hE001;
   localparam logic [15:0] REG_BANK_CTRL   = 16'h8000;
   localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
   localparam logic [15:0] REG_MIRRORING   = 16'hA000;
   localparam logic [15:0] REG_IRQ_PERIOD  = 16'hC000;
   localparam logic [15:0] REG_IRQ_REARM   = 16'hC001;
   localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
   localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

   // Address windows.
   localparam logic [15:0] ADDR_PRG_RAM_BASE = 16'h6000;
   localparam logic [15:0] ADDR_REG_BASE     = 16'h8000;
   localparam logic [15:0] ADDR_PPU_LIMIT    = 16'h2000;

   // Reset values of the configuration registers.
   localparam logic [8:0] RST_PRG_BANK_COUNT = 9'd2;
   localparam logic [8:0] RST_CHR_BANK_COUNT = 9'd8;
   localparam logic [1:0] RST_CHR_KIND       = 2'd1;
   localparam logic       RST_PRG_RAM        = 1'b1;
   localparam logic [7:0] RST_A12_FILTER     = 8'd12;

   // Largest bank count that the mapper honors.
   localparam logic [8:0] MAX_BANK_COUNT = 9'd256;

   // Request and reply of the shared remainder unit.
   typedef struct packed {
      logic       start;
      logic [7:0] dividend;
      logic [8:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] remainder;
   } div_rsp_type;

   // Bank register values after reset.
   function automatic logic [7:0] bank_reset_value(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'd0;
         3'd1: val = 8'd2;
         3'd2: val = 8'd4;
         3'd3: val = 8'd5;
         3'd4: val = 8'd6;
         3'd5: val = 8'd7;
         3'd6: val = 8'd0;
         3'd7: val = 8'd1;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/bsm_divider.sv */
// Restoring remainder unit: one quotient bit per cycle.
module bsm_divider
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] dvd_ff, dvd_in;
   logic [8:0] dsr_ff, dsr_in;
   logic [8:0] trial;
   logic [8:0] rem_step;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   // The remainder stays below the divisor, so it always fits in eight bits.
   always_comb begin
      trial    = {rem_ff, dvd_ff[7]};
      rem_step = (trial >= dsr_ff) ? (trial - dsr_ff) : trial;
   end

   // Next values of the iteration registers.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         rem_in  = 8'd0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = rem_step[7:0];
         dvd_in  = {dvd_ff[6:0], 1'b0};
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state is reset, the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   // The last step's remainder is offered in the cycle it is formed.
   assign div_rsp.done      = busy_ff && (step_ff == 3'd7);
   assign div_rsp.remainder = rem_step[7:0];

endmodule

/* rtl/bank_switch_mapper_scanline_irq_core.sv */
// Top level of the bank switch mapper with scanline interrupt counter.
//
// Each request carries one bus event: a CPU read or write, a PPU read or
// write, an observation of PPU address line 12, or an interrupt acknowledge.
// Each request gives exactly one response with the target memory, the byte
// offset within it, the write enable and data, the interrupt line and the
// mirroring bit. Both channels use valid and ready; the csr port writes the
// five configuration registers with no wait.
//
// The block works on one request at a time. Program ROM reads and pattern
// accesses reduce the bank number modulo the bank count in a shared
// restoring remainder unit, one bit per cycle; the response becomes valid
// once the unit has delivered the remainder. All other requests show
// their response in the cycle after they are accepted.
//
// Reset is synchronous and restores every mapper and configuration register
// to its power-on value. While the receiver stalls the response holds and no
// new request is taken.
module bank_switch_mapper_scanline_irq_core
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [31:0] req_cycle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_target,
   output logic [20:0] rsp_memory_offset,
   output logic        rsp_write_enable,
   output logic [7:0]  rsp_store_data,
   output logic        rsp_irq_line,
   output logic        rsp_mirroring_select,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_write_data
);

   // Configuration registers.
   logic [8:0] prg_count_ff;
   logic [8:0] chr_count_ff;
   logic [1:0] chr_kind_ff;
   logic       prg_ram_ff;
   logic [7:0] a12_filter_ff;

   // Mapper state.
   state_type   state_ff, state_in;
   logic [2:0]  bank_sel_ff, bank_sel_in;
   logic [7:0]  bank_regs_ff [8];
   logic        bank_we;
   logic        prg_swap_ff, prg_swap_in;
   logic        chr_invert_ff, chr_invert_in;
   logic        mirroring_ff, mirroring_in;
   logic [7:0]  irq_period_ff, irq_period_in;
   logic [7:0]  irq_count_ff, irq_count_in;
   logic        irq_enable_ff, irq_enable_in;
   logic        irq_flag_ff, irq_flag_in;
   logic        irq_rearm_ff, irq_rearm_in;
   logic        line12_up_ff, line12_up_in;
   logic [31:0] last_high_ff, last_high_in;

   // Pending response.
   logic [2:0]  rsp_target_ff;
   logic [20:0] rsp_offset_ff;
   logic        rsp_we_ff;
   logic [7:0]  rsp_data_ff;
   logic [12:0] addr_low_ff;

   logic        accept;
   logic [8:0]  eff_prg_count;
   logic [8:0]  eff_chr_count;
   logic [7:0]  prg_bank;
   logic [7:0]  chr_bank;
   logic [2:0]  chr_reg;
   logic [2:0]  chr_idx;
   logic [7:0]  chr_val;
   logic [31:0] low_time;
   logic [7:0]  count_after;
   logic [2:0]  tgt;
   logic [20:0] direct_offset;
   logic        we;
   logic        need_div;
   logic        div_is_prg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign accept = req_valid && req_ready;

   // Effective bank counts: oversized counts clamp to 256; a zero count gives one program or eight pattern banks.
   always_comb begin
      if (prg_count_ff == 9'd0) begin
         eff_prg_count = 9'd1;
      end else if (prg_count_ff > MAX_BANK_COUNT) begin
         eff_prg_count = MAX_BANK_COUNT;
      end else begin
         eff_prg_count = prg_count_ff;
      end
      if (chr_count_ff == 9'd0) begin
         eff_chr_count = RST_CHR_BANK_COUNT;
      end else if (chr_count_ff > MAX_BANK_COUNT) begin
         eff_chr_count = MAX_BANK_COUNT;
      end else begin
         eff_chr_count = chr_count_ff;
      end
   end

   // Program bank of the 8 KiB slot. The last and second-to-last banks are
   // formed in eight bits; with a single bank the remainder is zero anyway.
   always_comb begin
      case (req_address[14:13])
         2'd0: prg_bank = prg_swap_ff ? (eff_prg_count[7:0] - 8'd2) : bank_regs_ff[6];
         2'd1: prg_bank = bank_regs_ff[7];
         2'd2: prg_bank = prg_swap_ff ? bank_regs_ff[6] : (eff_prg_count[7:0] - 8'd2);
         default: prg_bank = eff_prg_count[7:0] - 8'd1;
      endcase
   end

   // Pattern bank of the 1 KiB slot: four slots pair up as 2 KiB banks, the low four or, when inverted, the high four.
   always_comb begin
      chr_reg = req_address[12:10] ^ {chr_invert_ff, 2'b00};
      chr_idx = chr_reg[2] ? (chr_reg - 3'd2) : {1'b0, chr_reg[2:1]};
      chr_val = bank_regs_ff[chr_idx];
      chr_bank = chr_reg[2] ? chr_val : {chr_val[7:1], chr_reg[0]};
   end

   // Line 12 low time and the scanline counter's next value: reload when zero or rearmed, else decrement.
   always_comb begin
      low_time = req_cycle - last_high_ff;
      if ((irq_count_ff == 8'd0) || irq_rearm_ff) begin
         count_after = irq_period_ff;
      end else begin
         count_after = irq_count_ff - 8'd1;
      end
   end

   // Request decode: translation and the state changes it causes.
   always_comb begin
      tgt            = TGT_NONE;
      direct_offset  = 21'd0;
      we             = 1'b0;
      need_div       = 1'b0;
      div_is_prg     = 1'b0;
      bank_we        = 1'b0;
      bank_sel_in    = bank_sel_ff;
      prg_swap_in    = prg_swap_ff;
      chr_invert_in  = chr_invert_ff;
      mirroring_in   = mirroring_ff;
      irq_period_in  = irq_period_ff;
      irq_count_in   = irq_count_ff;
      irq_enable_in  = irq_enable_ff;
      irq_flag_in    = irq_flag_ff;
      irq_rearm_in   = irq_rearm_ff;
      line12_up_in   = line12_up_ff;
      last_high_in   = last_high_ff;
      case (req_operation)
         OP_CPU_READ, OP_CPU_WRITE: begin
            if (req_address >= ADDR_REG_BASE) begin
               if (req_operation == OP_CPU_READ) begin
                  tgt        = TGT_PRG_ROM;
                  need_div   = 1'b1;
                  div_is_prg = 1'b1;
               end else begin
                  case (req_address & REG_MASK)
                     REG_BANK_CTRL: begin
                        bank_sel_in   = req_write_data[2:0];
                        prg_swap_in   = req_write_data[6];
                        chr_invert_in = req_write_data[7];
                     end
                     REG_BANK_DATA:   bank_we = 1'b1;
                     REG_MIRRORING:   mirroring_in = req_write_data[0];
                     REG_IRQ_PERIOD:  irq_period_in = req_write_data;
                     REG_IRQ_REARM: begin
                        irq_count_in = 8'd0;
                        irq_rearm_in = 1'b1;
                     end
                     REG_IRQ_DISABLE: begin
                        irq_enable_in = 1'b0;
                        irq_flag_in   = 1'b0;
                     end
                     REG_IRQ_ENABLE:  irq_enable_in = 1'b1;
                     default: ;
                  endcase
               end
            end else if ((req_address >= ADDR_PRG_RAM_BASE) && prg_ram_ff) begin
               tgt           = TGT_PRG_RAM;
               direct_offset = {8'd0, req_address[12:0]};
               we            = (req_operation == OP_CPU_WRITE);
            end
         end
         OP_PPU_READ: begin
            if ((req_address < ADDR_PPU_LIMIT) &&
                ((chr_kind_ff == CHR_KIND_ROM) || (chr_kind_ff == CHR_KIND_RAM))) begin
               tgt      = (chr_kind_ff == CHR_KIND_ROM) ? TGT_CHR_ROM : TGT_CHR_RAM;
               need_div = 1'b1;
            end
         end
         OP_PPU_WRITE: begin
            if ((req_address < ADDR_PPU_LIMIT) && (chr_kind_ff == CHR_KIND_RAM)) begin
               tgt      = TGT_CHR_RAM;
               need_div = 1'b1;
               we       = 1'b1;
            end
         end
         OP_A12_OBS: begin
            if (req_address[12]) begin
               if (!line12_up_ff && (low_time > {24'd0, a12_filter_ff})) begin
                  irq_count_in = count_after;
                  irq_rearm_in = 1'b0;
                  if ((count_after == 8'd0) && irq_enable_ff) begin
                     irq_flag_in = 1'b1;
                  end
               end
               last_high_in = req_cycle;
               line12_up_in = 1'b1;
            end else begin
               line12_up_in = 1'b0;
            end
         end
         OP_IRQ_ACK: irq_flag_in = 1'b0;
         default: ;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = need_div ? ST_CALC : ST_RESP;
            end
         end
         ST_CALC: begin
            if (div_rsp.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and the request to the remainder unit.
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = div_is_prg ? prg_bank : chr_bank;
      div_req.divisor  = div_is_prg ? eff_prg_count : eff_chr_count;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            div_req.start = req_valid && need_div;
         end
         ST_CALC: ;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   bsm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff  <= RST_PRG_BANK_COUNT;
         chr_count_ff  <= RST_CHR_BANK_COUNT;
         chr_kind_ff   <= RST_CHR_KIND;
         prg_ram_ff    <= RST_PRG_RAM;
         a12_filter_ff <= RST_A12_FILTER;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PRG_BANK_COUNT: prg_count_ff  <= csr_write_data;
            CSR_CHR_BANK_COUNT: chr_count_ff  <= csr_write_data;
            CSR_CHR_KIND:       chr_kind_ff   <= csr_write_data[1:0];
            CSR_PRG_RAM:        prg_ram_ff    <= csr_write_data[0];
            CSR_A12_FILTER:     a12_filter_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Sequencer state, and mapper state updated when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_sel_ff   <= 3'd0;
         prg_swap_ff   <= 1'b0;
         chr_invert_ff <= 1'b0;
         mirroring_ff  <= 1'b0;
         irq_period_ff <= 8'd0;
         irq_count_ff  <= 8'd0;
         irq_enable_ff <= 1'b0;
         irq_flag_ff   <= 1'b0;
         irq_rearm_ff  <= 1'b0;
         line12_up_ff  <= 1'b0;
         last_high_ff  <= 32'd0;
         for (int i = 0; i < 8; i++) begin
            bank_regs_ff[i] <= bank_reset_value(3'(i));
         end
      end else begin
         state_ff <= state_in;
         if (accept) begin
            bank_sel_ff   <= bank_sel_in;
            prg_swap_ff   <= prg_swap_in;
            chr_invert_ff <= chr_invert_in;
            mirroring_ff  <= mirroring_in;
            irq_period_ff <= irq_period_in;
            irq_count_ff  <= irq_count_in;
            irq_enable_ff <= irq_enable_in;
            irq_flag_ff   <= irq_flag_in;
            irq_rearm_ff  <= irq_rearm_in;
            line12_up_ff  <= line12_up_in;
            last_high_ff  <= last_high_in;
            if (bank_we) begin
               bank_regs_ff[bank_sel_ff] <= req_write_data;
            end
         end
      end
   end

   // Response payload: set at acceptance, offset completed by the remainder unit.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_target_ff <= tgt;
         rsp_offset_ff <= direct_offset;
         rsp_we_ff     <= we;
         rsp_data_ff   <= we ? req_write_data : 8'd0;
         addr_low_ff   <= req_address[12:0];
      end else if ((state_ff == ST_CALC) && div_rsp.done) begin
         if (rsp_target_ff == TGT_PRG_ROM) begin
            rsp_offset_ff <= {div_rsp.remainder, addr_low_ff};
         end else begin
            rsp_offset_ff <= {3'd0, div_rsp.remainder, addr_low_ff[9:0]};
         end
      end
   end

   assign rsp_target           = rsp_target_ff;
   assign rsp_memory_offset    = rsp_offset_ff;
   assign rsp_write_enable     = rsp_we_ff;
   assign rsp_store_data       = rsp_data_ff;
   assign rsp_irq_line         = irq_flag_ff;
   assign rsp_mirroring_select = mirroring_ff;

endmodule

/* rtl/bsm_checker.sv */
// Port-level checker of the bank switch mapper and its bind to the top level.
module bsm_checker
   import bsm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_target,
   input logic [20:0] rsp_memory_offset,
   input logic        rsp_write_enable,
   input logic [7:0]  rsp_store_data
);

   // A stalled response stays valid and keeps its target, offset and store data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) &&
         $stable(rsp_memory_offset) && $stable(rsp_store_data))
      else $error("stalled response changed");

   // One request at a time: no new request while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   // An accepted request makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted back to back");

   // A response without a target carries no offset and no store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == TGT_NONE) |->
         (rsp_memory_offset == 21'd0) && !rsp_write_enable)
      else $error("response without target has offset or store");

   // Store data is zero unless the response writes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> (rsp_store_data == 8'd0))
      else $error("store data without write enable");

endmodule

bind bank_switch_mapper_scanline_irq_core bsm_checker u_bsm_checker (.*);
